>>> rtl/core/serial_command_framer_top_assert.svh
// ----------------------------------------------------------------------------
// Serial command framer assertion macros
// Shared concurrent assertion forms for the framer checker.
// ----------------------------------------------------------------------------
`ifndef SERIAL_COMMAND_FRAMER_TOP_ASSERT_SVH
`define SERIAL_COMMAND_FRAMER_TOP_ASSERT_SVH

// Assertion that is switched off while reset is high.
`define SCF_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Assertion that is checked on every clock edge, reset included.
`define SCF_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> rtl/core/scf_pkg.sv
// ----------------------------------------------------------------------------
// Serial command framer package
// Item types, the queued command format and the framing constants.
// ----------------------------------------------------------------------------
package scf_pkg;

   // Framing constants.
   localparam logic [7:0] SYNC_BYTE  = 8'hAA;
   localparam logic [7:0] MAX_PARAMS = 8'd253;
   localparam logic [7:0] LEN_EXTRA  = 8'd2;

   // One input item.
   typedef struct packed {
      logic       start_req;
      logic [7:0] cmd_id;
      logic [7:0] ctrl_byte;
      logic [7:0] param_count;
      logic       has_param;
      logic [7:0] param_byte;
   } scf_req_type;

   // One result item.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       frame_end;
   } scf_rsp_type;

   // Classified item: which bytes to send and their values.
   typedef struct packed {
      logic       hdr;
      logic [7:0] len;
      logic [7:0] id;
      logic [7:0] ctrl;
      logic       prm;
      logic [7:0] pbyte;
      logic       chk;
      logic [7:0] cbyte;
   } scf_cmd_type;

   // Queue status seen by its producer and consumer.
   typedef struct packed {
      logic full;
      logic not_empty;
   } scf_qstat_type;

endpackage

>>> rtl/core/scf_queue.sv
// ----------------------------------------------------------------------------
// Serial command framer command queue
// Small register queue between the classifying front and the serializer.
// ----------------------------------------------------------------------------
module scf_queue import scf_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  scf_cmd_type   push_cmd,
   input  logic          pop,
   output scf_cmd_type   head,
   output scf_qstat_type stat
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   scf_cmd_type      mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // Status and head entry.
   assign stat.full      = (count_ff == FULL_CNT);
   assign stat.not_empty = (count_ff != '0);
   assign head           = mem_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

>>> rtl/core/scf_front.sv
// ----------------------------------------------------------------------------
// Serial command framer front
// Accepts items, tracks the open frame and its checksum, and queues commands.
// ----------------------------------------------------------------------------
module scf_front import scf_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  scf_req_type   req_data,
   input  scf_qstat_type qstat,
   output logic          push,
   output scf_cmd_type   push_cmd
);

   logic [7:0] sum_ff, sum_in;
   logic [7:0] left_ff, left_in;
   logic       open_ff, open_in;

   logic       accept;
   logic [7:0] count_sat;
   logic [7:0] base_sum;
   logic [7:0] base_left;
   logic       take_param;
   logic       chk;

   assign req_stall = qstat.full;
   assign accept    = req_valid && !qstat.full;

   // Classify the item and work out the frame state after it.
   always_comb begin
      count_sat  = (req_data.param_count > MAX_PARAMS) ? MAX_PARAMS : req_data.param_count;
      base_sum   = req_data.start_req ? (req_data.cmd_id + req_data.ctrl_byte) : sum_ff;
      base_left  = req_data.start_req ? count_sat : left_ff;
      take_param = req_data.has_param &&
                   (req_data.start_req ? (count_sat != 8'd0) : open_ff);
      sum_in     = base_sum + (take_param ? req_data.param_byte : 8'd0);
      left_in    = base_left - {7'd0, take_param};
      chk        = (take_param && (base_left == 8'd1)) ||
                   (req_data.start_req && (count_sat == 8'd0));
      open_in    = (req_data.start_req || open_ff) && !chk;

      push_cmd.hdr   = req_data.start_req;
      push_cmd.len   = count_sat + LEN_EXTRA;
      push_cmd.id    = req_data.cmd_id;
      push_cmd.ctrl  = req_data.ctrl_byte;
      push_cmd.prm   = take_param;
      push_cmd.pbyte = req_data.param_byte;
      push_cmd.chk   = chk;
      push_cmd.cbyte = 8'd0 - sum_in;
   end

   // Only items that cause bytes enter the queue and change the state.
   assign push = accept && (req_data.start_req || take_param);

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff  <= '0;
         left_ff <= '0;
         open_ff <= 1'b0;
      end else if (push) begin
         sum_ff  <= sum_in;
         left_ff <= left_in;
         open_ff <= open_in;
      end
   end

endmodule

>>> rtl/core/scf_back.sv
// ----------------------------------------------------------------------------
// Serial command framer back
// Serializes queued commands into frame bytes, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module scf_back import scf_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  scf_qstat_type qstat,
   input  scf_cmd_type   head,
   output logic          pop,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output scf_rsp_type   rsp_data
);

   typedef enum logic [2:0] {
      STEP_SYNC0,
      STEP_SYNC1,
      STEP_LEN,
      STEP_ID,
      STEP_CTRL,
      STEP_PARAM,
      STEP_CHECK
   } step_type;

   step_type    step_ff, step_in;
   logic        active_ff, active_in;
   logic        rsp_valid_ff;
   scf_rsp_type rsp_ff, rsp_in;

   step_type    cur_step;
   logic        emit;
   logic        last;

   // Step of the head command that goes out next.
   always_comb begin
      if (active_ff) begin
         cur_step = step_ff;
      end else if (head.hdr) begin
         cur_step = STEP_SYNC0;
      end else if (head.prm) begin
         cur_step = STEP_PARAM;
      end else begin
         cur_step = STEP_CHECK;
      end
   end

   // Byte selection and the following step.
   always_comb begin
      step_in = STEP_CHECK;
      last    = 1'b1;
      rsp_in.out_byte  = head.cbyte;
      rsp_in.frame_end = 1'b0;
      unique case (cur_step)
         STEP_SYNC0: begin
            rsp_in.out_byte = SYNC_BYTE;
            step_in = STEP_SYNC1;
            last    = 1'b0;
         end
         STEP_SYNC1: begin
            rsp_in.out_byte = SYNC_BYTE;
            step_in = STEP_LEN;
            last    = 1'b0;
         end
         STEP_LEN: begin
            rsp_in.out_byte = head.len;
            step_in = STEP_ID;
            last    = 1'b0;
         end
         STEP_ID: begin
            rsp_in.out_byte = head.id;
            step_in = STEP_CTRL;
            last    = 1'b0;
         end
         STEP_CTRL: begin
            rsp_in.out_byte = head.ctrl;
            step_in = head.prm ? STEP_PARAM : STEP_CHECK;
            last    = !head.prm && !head.chk;
         end
         STEP_PARAM: begin
            rsp_in.out_byte = head.pbyte;
            step_in = STEP_CHECK;
            last    = !head.chk;
         end
         STEP_CHECK: begin
            rsp_in.out_byte  = head.cbyte;
            rsp_in.frame_end = 1'b1;
         end
         default: begin
            last = 1'b1;
         end
      endcase
   end

   // A queued command's byte goes out when the output is free or being taken.
   assign emit      = qstat.not_empty && (!rsp_valid_ff || !rsp_stall);
   assign pop       = emit && last;
   assign active_in = !last;

   // Serializer state and the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         step_ff      <= STEP_SYNC0;
         rsp_valid_ff <= 1'b0;
         rsp_ff       <= '0;
      end else if (emit) begin
         active_ff    <= active_in;
         step_ff      <= step_in;
         rsp_valid_ff <= 1'b1;
         rsp_ff       <= rsp_in;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> rtl/core/serial_command_framer_top.sv
// ----------------------------------------------------------------------------
// Serial command framer
// Turns command items into a framed byte stream with a trailing checksum.
// ----------------------------------------------------------------------------
// The block takes one input item per cycle while its command queue has room
// and sends one frame byte per cycle, when not stalled, through a registered
// output. A start item produces five header bytes (two sync bytes, length,
// id, control), then a parameter byte if it carries one and the checksum if
// the frame is complete, five to seven bytes in all; a parameter item
// produces one or two bytes. The serializer's one byte per cycle sets the
// sustained output rate, and the queue depth (QUEUE_DEPTH commands) sets
// how many items can be taken ahead while earlier bytes are still going out.
module serial_command_framer_top import scf_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  scf_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output scf_rsp_type rsp_data
);

   scf_qstat_type qstat;
   scf_cmd_type   push_cmd;
   scf_cmd_type   head;
   logic          push;
   logic          pop;

   // Front: classification and frame state.
   scf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .qstat     (qstat),
      .push      (push),
      .push_cmd  (push_cmd)
   );

   // Queue between front and back.
   scf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .stat     (qstat)
   );

   // Back: byte serializer and output register.
   scf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .qstat     (qstat),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

>>> rtl/core/scf_checker.sv
// ----------------------------------------------------------------------------
// Serial command framer port checker
// Checks the framer's ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
`include "serial_command_framer_top_assert.svh"

module scf_checker import scf_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input scf_req_type req_data,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input scf_rsp_type rsp_data
);

   logic start_taken;

   assign start_taken = req_valid && !req_stall && req_data.start_req;

   // A stalled result item stays offered.
   `SCF_ASSERT(a_rsp_hold_valid, rsp_valid && rsp_stall |=> rsp_valid, "stalled rsp_valid dropped")

   // A stalled result item keeps its payload.
   `SCF_ASSERT(a_rsp_hold_data, rsp_valid && rsp_stall |=> $stable(rsp_data), "stalled rsp_data changed")

   // No result item is offered in the cycle after a reset cycle.
   `SCF_ASSERT_ALWAYS(a_rsp_reset, reset |=> !rsp_valid, "rsp_valid high after reset")

   // Once an accepted start item has passed the queue and the output register,
   // a result is on offer: its own first byte or an earlier byte still waiting.
   `SCF_ASSERT(a_start_output, start_taken |=> ##1 rsp_valid, "no result after start item")

endmodule

bind serial_command_framer_top scf_checker u_scf_checker (.*);
